// ===== rtl/core/dtwn_pkg.sv =====
// dtwn_pkg: shared types, widths and constants of the length-normalised DTW unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dtwn_pkg;

  // Defaults of the top-level size parameters
  localparam int DTWN_MAX_ROWS = 256;
  localparam int DTWN_MAX_COLS = 1024;

  // Fixed field widths
  localparam int COST_IN_W = 16;            // local cost, Q8.8
  localparam int COST_W    = 27;            // accumulated cost, Q19.8
  localparam int LEN_W     = 11;            // path length
  localparam int ROW_OUT_W = 8;             // reported end row
  localparam int NORM_W    = 24;            // normalised cost, Q8.16
  localparam int FRAC_SH   = 8;             // extra fraction bits of the quotient
  localparam int DVD_W     = COST_W + FRAC_SH;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // Configuration port
  localparam int ROWS_CFG_W = 9;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
  localparam logic [ROWS_CFG_W-1:0] RESET_ROWS = 9'd256;
  localparam logic [COLS_CFG_W-1:0] RESET_COLS = 11'd1024;

  // Compare widths wide enough for any legal position counter plus one
  localparam int ROW_CMP_W = 13;
  localparam int COL_CMP_W = 17;

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified cell travelling from front to back
  typedef struct packed {
    logic [COST_IN_W-1:0] local_cost;
    logic                 first_row;
    logic                 first_col;
    logic                 last_row;
    logic                 last_col;
  } cell_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DIV
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtwn_fifo.sv =====
// dtwn_fifo: short first-in first-out queue of classified cells.
// Depends on dtwn_pkg (cell_t, QDEPTH).
`timescale 1ns / 1ps
`default_nettype none

module dtwn_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dtwn_pkg::cell_t push_data,
  output logic                full,
  input  wire logic           pop,
  output dtwn_pkg::cell_t     pop_data,
  output logic                not_empty
);
  import dtwn_pkg::*;

  cell_t          slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtwn_front.sv =====
// dtwn_front: size registers, matrix position counters and cell classification.
// Depends on dtwn_pkg; feeds dtwn_fifo.
`timescale 1ns / 1ps
`default_nettype none

module dtwn_front #(
  parameter int MAX_ROWS = dtwn_pkg::DTWN_MAX_ROWS,
  parameter int MAX_COLS = dtwn_pkg::DTWN_MAX_COLS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dtwn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dtwn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [dtwn_pkg::COST_IN_W-1:0]      in_local_cost,
  output logic                                     push,
  output dtwn_pkg::cell_t                          push_data,
  input  wire logic                                full
);
  import dtwn_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [ROW_CMP_W-1:0] ROWS_LIM = ROW_CMP_W'(MAX_ROWS);
  localparam logic [COL_CMP_W-1:0] COLS_LIM = COL_CMP_W'(MAX_COLS);

  logic [ROWS_CFG_W-1:0] rows_r;
  logic [COLS_CFG_W-1:0] cols_r;
  logic [RW-1:0]         m_r;
  logic [CW-1:0]         n_r;
  logic                  last_row;
  logic                  last_col;

  // zero acts as one, oversize acts as the maximum
  function automatic logic [ROWS_CFG_W-1:0] clamp_rows(input logic [ROWS_CFG_W-1:0] v);
    logic [ROW_CMP_W-1:0] w;
    w = ROW_CMP_W'(v);
    if (v == '0) return ROWS_CFG_W'(1);
    if (w > ROWS_LIM) return ROWS_LIM[ROWS_CFG_W-1:0];
    return v;
  endfunction

  function automatic logic [COLS_CFG_W-1:0] clamp_cols(input logic [COLS_CFG_W-1:0] v);
    logic [COL_CMP_W-1:0] w;
    w = COL_CMP_W'(v);
    if (v == '0) return COLS_CFG_W'(1);
    if (w > COLS_LIM) return COLS_LIM[COLS_CFG_W-1:0];
    return v;
  endfunction

  assign last_row = ((ROW_CMP_W'(m_r) + ROW_CMP_W'(1)) >= ROW_CMP_W'(rows_r));
  assign last_col = ((COL_CMP_W'(n_r) + COL_CMP_W'(1)) >= COL_CMP_W'(cols_r));

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data.local_cost = in_local_cost;
    push_data.first_row  = (m_r == '0);
    push_data.first_col  = (n_r == '0);
    push_data.last_row   = last_row;
    push_data.last_col   = last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= clamp_rows(RESET_ROWS);
      cols_r <= clamp_cols(RESET_COLS);
      m_r    <= '0;
      n_r    <= '0;
    end else if (cfg_we) begin
      // any write restarts the matrix
      m_r <= '0;
      n_r <= '0;
      if (cfg_index == REG_ROWS) begin
        rows_r <= clamp_rows(cfg_wdata[ROWS_CFG_W-1:0]);
      end else if (cfg_index == REG_COLS) begin
        cols_r <= clamp_cols(cfg_wdata[COLS_CFG_W-1:0]);
      end
    end else if (push) begin
      if (!last_row) begin
        m_r <= m_r + 1'b1;
      end else begin
        m_r <= '0;
        n_r <= last_col ? '0 : n_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtwn_div.sv =====
// dtwn_div: restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on dtwn_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none

module dtwn_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dtwn_pkg::DVD_W-1:0]    dividend,
  input  wire logic [dtwn_pkg::LEN_W-1:0]    divisor,
  output logic                               done,
  output logic [dtwn_pkg::NORM_W-1:0]        quotient
);
  import dtwn_pkg::*;

  logic [DVD_W-1:0]     dvd_r;    // dividend shifts out, quotient shifts in
  logic [LEN_W-1:0]     div_r;
  logic [LEN_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [LEN_W:0]       trial;
  logic                 qbit;
  logic [LEN_W-1:0]     rem_nxt;
  logic [LEN_W:0]       diff;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, div_r};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
  end

  assign done     = done_r;
  assign quotient = (|dvd_r[DVD_W-1:NORM_W]) ? '1 : dvd_r[NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= (divisor == '0) ? LEN_W'(1) : divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtwn_back.sv =====
// dtwn_back: cost recursion, previous-column store, last-column minimum, result register.
// Depends on dtwn_pkg and dtwn_div.
`timescale 1ns / 1ps
`default_nettype none

module dtwn_back #(
  parameter int MAX_ROWS = dtwn_pkg::DTWN_MAX_ROWS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              restart,
  input  wire logic                              q_valid,
  input  wire dtwn_pkg::cell_t                   q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dtwn_pkg::ROW_OUT_W-1:0]         out_best_end_row,
  output logic [dtwn_pkg::COST_W-1:0]            out_accumulated_cost,
  output logic [dtwn_pkg::LEN_W-1:0]             out_path_length,
  output logic [dtwn_pkg::NORM_W-1:0]            out_normalized_cost
);
  import dtwn_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  back_state_t state_r, state_nxt;

  logic [COST_W+LEN_W-1:0] col_mem [MAX_ROWS];
  logic [COST_W+LEN_W-1:0] rd_r;

  cell_t              cell_r;
  logic [RW-1:0]      m_r;
  logic [RW+7:0]      m_ext;
  logic [COST_W-1:0]  above_cost_r, diag_cost_r, best_cost_r, pend_cost_r;
  logic [LEN_W-1:0]   above_len_r, diag_len_r, best_len_r, pend_len_r;
  logic [ROW_OUT_W-1:0] best_row_r, pend_row_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [NORM_W-1:0]  out_norm_r;
  logic               out_valid_r;

  logic [COST_W-1:0]  left_c, bc, cost;
  logic [LEN_W-1:0]   left_l, bl, len;
  logic [COST_W:0]    sum_c;
  logic [LEN_W:0]     sum_l;
  logic               upd_best;
  logic [COST_W-1:0]  best_cost_nxt;
  logic [LEN_W-1:0]   best_len_nxt;
  logic [ROW_OUT_W-1:0] best_row_nxt;
  logic               do_calc, final_cell, load_out, div_start, div_done;
  logic [NORM_W-1:0]  div_q;

  assign m_ext = {8'd0, m_r};

  // ---- cell recursion ----
  always_comb begin
    left_c = cell_r.first_col ? '0 : rd_r[COST_W+LEN_W-1:LEN_W];
    left_l = cell_r.first_col ? '0 : rd_r[LEN_W-1:0];
    if (cell_r.first_row && cell_r.first_col) begin
      bc = '0;
      bl = '0;
    end else if (cell_r.first_col) begin
      bc = above_cost_r;
      bl = above_len_r;
    end else if (cell_r.first_row) begin
      bc = left_c;
      bl = left_l;
    end else if (diag_cost_r <= above_cost_r && diag_cost_r <= left_c) begin
      bc = diag_cost_r;
      bl = diag_len_r;
    end else if (above_cost_r <= left_c) begin
      bc = above_cost_r;
      bl = above_len_r;
    end else begin
      bc = left_c;
      bl = left_l;
    end
    sum_c = {1'b0, bc} + (COST_W+1)'(cell_r.local_cost);
    sum_l = {1'b0, bl} + (LEN_W+1)'(1);
    cost  = sum_c[COST_W] ? '1 : sum_c[COST_W-1:0];
    len   = sum_l[LEN_W] ? '1 : sum_l[LEN_W-1:0];

    upd_best      = cell_r.last_col && (cell_r.first_row || cost < best_cost_r);
    best_cost_nxt = upd_best ? cost : best_cost_r;
    best_len_nxt  = upd_best ? len : best_len_r;
    best_row_nxt  = upd_best ? m_ext[ROW_OUT_W-1:0] : best_row_r;
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    do_calc   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!restart && q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        do_calc = 1'b1;
        if (cell_r.last_row && cell_r.last_col) begin
          div_start = 1'b1;
          state_nxt = BK_DIV;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (div_done && (!out_valid_r || out_ready)) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign final_cell = div_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- previous-column store ----
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= col_mem[m_r];
    end
    if (do_calc) begin
      col_mem[m_r] <= {cost, len};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cell_r <= q_data;
    end
    if (final_cell) begin
      pend_row_r  <= best_row_nxt;
      pend_cost_r <= best_cost_nxt;
      pend_len_r  <= best_len_nxt;
    end
    if (load_out) begin
      out_row_r  <= pend_row_r;
      out_cost_r <= pend_cost_r;
      out_len_r  <= pend_len_r;
      out_norm_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      m_r          <= '0;
      above_cost_r <= '0;
      above_len_r  <= '0;
      diag_cost_r  <= '0;
      diag_len_r   <= '0;
      best_cost_r  <= '0;
      best_len_r   <= '0;
      best_row_r   <= '0;
    end else if (do_calc) begin
      if (final_cell) begin
        above_cost_r <= '0;
        above_len_r  <= '0;
        diag_cost_r  <= '0;
        diag_len_r   <= '0;
        best_cost_r  <= '0;
        best_len_r   <= '0;
        best_row_r   <= '0;
      end else begin
        above_cost_r <= cost;
        above_len_r  <= len;
        diag_cost_r  <= left_c;
        diag_len_r   <= left_l;
        best_cost_r  <= best_cost_nxt;
        best_len_r   <= best_len_nxt;
        best_row_r   <= best_row_nxt;
      end
      m_r <= cell_r.last_row ? '0 : m_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  dtwn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({best_cost_nxt, FRAC_SH'(0)}),
    .divisor  (best_len_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid            = out_valid_r;
  assign out_best_end_row     = out_row_r;
  assign out_accumulated_cost = out_cost_r;
  assign out_path_length      = out_len_r;
  assign out_normalized_cost  = out_norm_r;

endmodule

`default_nettype wire

// ===== rtl/core/dtw_normalized_cost_endpoint_unit.sv =====
// Length-normalised DTW end-point unit: takes local costs column-major, returns the
// best last-column end cell with its cost, path length and cost per cell.
// Each cell is read from the store, then goes through recursion and write-back; the back
// takes no new cell until that write-back. Once per matrix the 35-bit restoring divider runs
// before the result is given.
// Reset is synchronous, active low; sizes return to 256 x 1024, store left uninitialised.
`timescale 1ns / 1ps
`default_nettype none

module dtw_normalized_cost_endpoint_unit #(
  parameter int MAX_ROWS = dtwn_pkg::DTWN_MAX_ROWS,
  parameter int MAX_COLS = dtwn_pkg::DTWN_MAX_COLS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration: write-only; the user must write it only while the unit is idle, the block does not enforce this
  input  wire logic                               cfg_we,
  input  wire logic [dtwn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtwn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // local cost stream
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dtwn_pkg::COST_IN_W-1:0]     in_local_cost,
  // one result per matrix
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [dtwn_pkg::ROW_OUT_W-1:0]          out_best_end_row,
  output logic [dtwn_pkg::COST_W-1:0]             out_accumulated_cost,
  output logic [dtwn_pkg::LEN_W-1:0]              out_path_length,
  output logic [dtwn_pkg::NORM_W-1:0]             out_normalized_cost
);
  import dtwn_pkg::*;

  // Front: keeps the matrix position and tags each transfer with its
  // first/last row and column flags, so the back needs no size registers.
  cell_t push_data;
  cell_t q_data;
  logic  push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  dtwn_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_local_cost (in_local_cost),
    .push          (push),
    .push_data     (push_data),
    .full          (q_full)
  );

  // Short queue: until it fills, the stream keeps flowing while the back waits on the
  // divider or on a result that has not yet been taken.
  dtwn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // Back: previous-column store, three-way minimum with diagonal-then-upper
  // priority, last-column minimum (lowest row wins a tie) and the divider.
  // A configuration write restarts the matrix on both sides.
  dtwn_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .restart              (cfg_we),
    .q_valid              (q_valid),
    .q_data               (q_data),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_best_end_row     (out_best_end_row),
    .out_accumulated_cost (out_accumulated_cost),
    .out_path_length      (out_path_length),
    .out_normalized_cost  (out_normalized_cost)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dtwn_check.sv =====
// dtwn_check: port-level assertions for the DTW end-point unit, bound to the top level.
// Depends on dtwn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module dtwn_check (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [dtwn_pkg::COST_IN_W-1:0]     in_local_cost,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [dtwn_pkg::ROW_OUT_W-1:0]     out_best_end_row,
  input wire logic [dtwn_pkg::COST_W-1:0]        out_accumulated_cost,
  input wire logic [dtwn_pkg::LEN_W-1:0]         out_path_length,
  input wire logic [dtwn_pkg::NORM_W-1:0]        out_normalized_cost
);
  import dtwn_pkg::*;

  // a waiting input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_local_cost))
    else $error("input changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accumulated_cost)
      && $stable(out_normalized_cost) && $stable(out_best_end_row)
      && $stable(out_path_length))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  // a path holds at least one cell
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_path_length != '0)
    else $error("zero path length");

  // a one-cell path: quotient is the cost with the fraction extended
  a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_length == LEN_W'(1) && out_accumulated_cost[COST_W-1:COST_IN_W] == '0
      |-> out_normalized_cost == {out_accumulated_cost[COST_IN_W-1:0], 8'h00})
    else $error("normalised cost wrong for one-cell path");

endmodule

bind dtw_normalized_cost_endpoint_unit dtwn_check u_check (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for the length-normalised DTW end-point unit.
// Needs dtwn_pkg and dtw_normalized_cost_endpoint_unit; reads no files.
`timescale 1ns / 1ps

module tb;
  import dtwn_pkg::*;

  localparam int SETTLE_CYCLES = 100;        // latency of the last cell plus the divider
  localparam int LONG_HOLD     = 300;        // receiver back-pressure stretch
  localparam int LIMIT_NS      = 10_000_000; // watchdog time limit

  typedef enum int {FILL_RANDOM, FILL_TIES, FILL_HIGH, FILL_MAX, FILL_ZERO} fill_t;

  typedef struct {
    logic [ROW_OUT_W-1:0] row;
    logic [COST_W-1:0]    cost;
    logic [LEN_W-1:0]     len;
    logic [NORM_W-1:0]    norm;
  } endpoint_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COST_IN_W-1:0]  in_local_cost = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_OUT_W-1:0]  out_best_end_row;
  logic [COST_W-1:0]     out_accumulated_cost;
  logic [LEN_W-1:0]      out_path_length;
  logic [NORM_W-1:0]     out_normalized_cost;

  dtw_normalized_cost_endpoint_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_local_cost        (in_local_cost),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_best_end_row     (out_best_end_row),
    .out_accumulated_cost (out_accumulated_cost),
    .out_path_length      (out_path_length),
    .out_normalized_cost  (out_normalized_cost)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: effective sizes, the one-column store and the running
  // neighbours of the current cell. Sizes start at the reset values 256 x 1024.
  // ---------------------------------------------------------------------------
  logic [COST_W-1:0]    col_cost [DTWN_MAX_ROWS];
  logic [LEN_W-1:0]     col_len  [DTWN_MAX_ROWS];
  int unsigned          rows_eff = DTWN_MAX_ROWS;
  int unsigned          cols_eff = DTWN_MAX_COLS;
  int unsigned          row_pos = 0, col_pos = 0;
  logic [COST_W-1:0]    up_cost = '0, diag_cost = '0, best_cost = '0;
  logic [LEN_W-1:0]     up_len = '0, diag_len = '0, best_len = '0;
  logic [ROW_OUT_W-1:0] best_row = '0;

  endpoint_t            endpoint_q[$];   // expected end points, oldest first
  logic [COST_IN_W-1:0] cost_q[$];       // local costs still to be offered
  int unsigned          cells_queued = 0, cells_taken = 0, mismatches = 0;
  bit                   tx_quiet = 1'b0, rx_quiet = 1'b0;
  int unsigned          tx_wait = 0, rx_wait = 0;
  logic                 hold_armed = 1'b0;
  bit                   hold_done = 1'b0;

  // A register write, or the end of a matrix, starts a fresh matrix.
  task automatic clear_matrix();
    row_pos = 0;
    col_pos = 0;
    up_cost = '0;
    up_len = '0;
    diag_cost = '0;
    diag_len = '0;
    best_cost = '0;
    best_len = '0;
    best_row = '0;
  endtask

  // 0 acts as 1; anything above the maximum size acts as the maximum size.
  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // One cell of the recursion. Column 0 only looks up, row 0 only looks left;
  // otherwise the cheapest of diagonal, upper, left, ties in that order.
  task automatic accumulate_cell(input logic [COST_IN_W-1:0] d);
    logic [COST_W-1:0] left_c, base_c, c;
    logic [LEN_W-1:0]  left_l, base_l, l;
    logic [DVD_W-1:0]  quot;
    endpoint_t         ep;
    left_c = '0;
    left_l = '0;
    if (col_pos > 0) begin
      left_c = col_cost[row_pos];
      left_l = col_len[row_pos];
    end
    if (row_pos == 0 && col_pos == 0) begin
      base_c = '0;
      base_l = '0;
    end else if (col_pos == 0) begin
      base_c = up_cost;
      base_l = up_len;
    end else if (row_pos == 0) begin
      base_c = left_c;
      base_l = left_l;
    end else if (diag_cost <= up_cost && diag_cost <= left_c) begin
      base_c = diag_cost;
      base_l = diag_len;
    end else if (up_cost <= left_c) begin
      base_c = up_cost;
      base_l = up_len;
    end else begin
      base_c = left_c;
      base_l = left_l;
    end
    c = base_c + d;      // no overflow at the default sizes
    l = base_l + 1'b1;

    // the old left entry becomes the diagonal of the next row down
    diag_cost = left_c;
    diag_len  = left_l;
    up_cost   = c;
    up_len    = l;
    col_cost[row_pos] = c;
    col_len[row_pos]  = l;

    // end-point search over the last column, strict less keeps the lowest row
    if (col_pos + 1 >= cols_eff && (row_pos == 0 || c < best_cost)) begin
      best_cost = c;
      best_len  = l;
      best_row  = row_pos[ROW_OUT_W-1:0];
    end

    if (row_pos + 1 < rows_eff) begin
      row_pos++;
    end else begin
      row_pos = 0;
      if (col_pos + 1 < cols_eff) begin
        col_pos++;
      end else begin
        quot     = {best_cost, {FRAC_SH{1'b0}}} / best_len;
        ep.row   = best_row;
        ep.cost  = best_cost;
        ep.len   = best_len;
        ep.norm  = (quot > {NORM_W{1'b1}}) ? {NORM_W{1'b1}} : quot[NORM_W-1:0];
        endpoint_q.push_back(ep);
        clear_matrix();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // Per-item wait drawn at random; a quiet spell gives back-to-back transfers.
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers cost_q one transfer at a time, predicts on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_cell(in_local_cost);
        cells_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait  <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (cost_q.size() > 0) begin
          in_valid      <= 1'b1;
          in_local_cost <= cost_q.pop_front();
          tx_wait       <= draw_wait(tx_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result transfer against the oldest end point, then
  // waits a drawn number of cycles. Once armed it holds off for a long stretch
  // so the unit backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int unsigned hold;
    endpoint_t   want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      hold = rx_wait;
      if (out_valid && out_ready) begin
        if (endpoint_q.size() == 0) begin
          report_mismatch("result with nothing expected, row", out_best_end_row, 0);
        end else begin
          want = endpoint_q.pop_front();
          if (out_best_end_row !== want.row)
            report_mismatch("best_end_row", out_best_end_row, want.row);
          if (out_accumulated_cost !== want.cost)
            report_mismatch("accumulated_cost", out_accumulated_cost, want.cost);
          if (out_path_length !== want.len)
            report_mismatch("path_length", out_path_length, want.len);
          if (out_normalized_cost !== want.norm)
            report_mismatch("normalized_cost", out_normalized_cost, want.norm);
        end
        hold = draw_wait(rx_quiet);
        if (hold_armed && !hold_done) begin
          hold = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= hold - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait   <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Register write while idle; the predictor follows and restarts its matrix.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) rows_eff = clamp_size(val[ROWS_CFG_W-1:0], DTWN_MAX_ROWS);
    else cols_eff = clamp_size(val[COLS_CFG_W-1:0], DTWN_MAX_COLS);
    clear_matrix();
  endtask

  task automatic queue_cells(input fill_t kind, input int unsigned count);
    logic [COST_IN_W-1:0] v;
    repeat (count) begin
      case (kind)
        FILL_TIES: v = COST_IN_W'($urandom_range(0, 3));
        FILL_HIGH: v = {COST_IN_W{1'b1}} - COST_IN_W'($urandom_range(0, 3));
        FILL_MAX:  v = {COST_IN_W{1'b1}};
        FILL_ZERO: v = '0;
        default:   v = COST_IN_W'($urandom_range(0, 65535));
      endcase
      cost_q.push_back(v);
      cells_queued++;
    end
  endtask

  // Idle point: everything taken, every end point seen, and the pipe empty
  // even where the last cells belonged to an unfinished matrix.
  task automatic settle();
    while (cells_taken != cells_queued || endpoint_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic fill_t pick_fill();
    case ($urandom_range(0, 5))
      3, 4:    return FILL_TIES;
      5:       return FILL_HIGH;
      default: return FILL_RANDOM;
    endcase
  endfunction

  function automatic int unsigned pick_size();
    return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  initial begin : stimulus
    int unsigned rand_cells, rand_mats, n_mats, rows_v, cols_v;
    rand_cells = 0;
    rand_mats  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero sizes act as 1 x 1, both cost extremes
    write_reg(REG_ROWS, 11'h000);
    write_reg(REG_COLS, 11'h000);
    queue_cells(FILL_MAX, 1);
    queue_cells(FILL_ZERO, 1);
    settle();

    // 3 x 4 with ignored upper row bits set; all-equal costs so the diagonal
    // is never dearer than a neighbour and must win
    write_reg(REG_ROWS, 11'h603);
    write_reg(REG_COLS, 11'd4);
    queue_cells(FILL_MAX, 12);
    settle();

    // unfinished matrix, then a register write restarts it with no result
    write_reg(REG_ROWS, 11'd2);
    write_reg(REG_COLS, 11'd3);
    queue_cells(FILL_RANDOM, 3);
    settle();
    write_reg(REG_COLS, 11'd3);
    queue_cells(FILL_TIES, 6);
    settle();

    // Size extremes: rows above the store act as 256, one full column
    write_reg(REG_ROWS, 11'h7FF);
    write_reg(REG_COLS, 11'd1);
    queue_cells(FILL_HIGH, 256);
    settle();
    // cols above the limit act as 1024: a short run on one row gives no result
    write_reg(REG_COLS, 11'h7FF);
    write_reg(REG_ROWS, 11'h200);   // low nine bits zero, acts as 1
    queue_cells(FILL_MAX, 40);
    settle();

    // Back-pressure: many tiny matrices while the receiver stops for a while
    write_reg(REG_ROWS, 11'd1);
    write_reg(REG_COLS, 11'd2);
    hold_armed <= 1'b1;
    queue_cells(FILL_RANDOM, 48);
    settle();

    // Random phases of small matrices, occasionally cut short
    while (rand_cells < 120 || rand_mats < 8) begin
      rows_v = pick_size();
      cols_v = pick_size();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_ROWS, {2'($urandom_range(0, 3)), 9'(rows_v)});
        write_reg(REG_COLS, CFG_DATA_W'(cols_v));
      end else begin
        write_reg(REG_COLS, CFG_DATA_W'(cols_v));
        write_reg(REG_ROWS, {2'($urandom_range(0, 3)), 9'(rows_v)});
      end
      n_mats = $urandom_range(1, 4);
      repeat (n_mats) begin
        queue_cells(pick_fill(), rows_eff * cols_eff);
        rand_cells += rows_eff * cols_eff;
      end
      rand_mats += n_mats;
      if (rows_eff * cols_eff > 1 && $urandom_range(0, 5) == 0) begin
        n_mats = $urandom_range(1, rows_eff * cols_eff - 1);
        queue_cells(FILL_RANDOM, n_mats);
        rand_cells += n_mats;
      end
      settle();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
